@@ design/kbst_pkg.sv @@
// ----------------------------------------------------------------------------
// kbst_pkg
// Shared types, codes and sizes of the key and button state tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package kbst_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int CODE_W      = 25;
  localparam int POS_W       = 16;
  localparam int DELTA_W     = 17;
  localparam int ENTRY_W     = CODE_W + 4;

  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_QUERY   = 2'd3
  } command_t;

  typedef enum logic [2:0] {
    ST_ABSENT       = 3'd0,
    ST_REGISTERED   = 3'd1,
    ST_TRIGGERED    = 3'd2,
    ST_PRESSED      = 3'd3,
    ST_UNREGISTERED = 3'd4,
    ST_RELEASED     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ctrl_state_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } kbst_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_last;
    logic out_free;
  } kbst_stat_t;

  // Status of a surviving entry after one frame tick
  function automatic status_t advance_status(input status_t s);
    status_t r;
    case (s)
      ST_REGISTERED:   r = ST_TRIGGERED;
      ST_TRIGGERED:    r = ST_PRESSED;
      ST_UNREGISTERED: r = ST_RELEASED;
      default:         r = s;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

@@ design/kbst_ram.sv @@
// ----------------------------------------------------------------------------
// kbst_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module kbst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ design/kbst_ctrl.sv @@
// ----------------------------------------------------------------------------
// kbst_ctrl
// Sequencer: accept one beat, walk the table, finish and hand off the result.
// ----------------------------------------------------------------------------
`default_nettype none

module kbst_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               s_tvalid,
  output      logic               s_tready,
  input  wire kbst_pkg::kbst_stat_t stat,
  output      kbst_pkg::kbst_cmd_t  cmd
);

  import kbst_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) state_next = S_SCAN;
      end
      S_SCAN: begin
        if (stat.scan_last) state_next = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        cmd.load = s_tvalid;
      end
      S_SCAN: begin
        cmd.step = 1'b1;
      end
      S_FINISH: begin
        // hold until the output register can take the result
        cmd.finish = stat.out_free;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/kbst_datapath.sv @@
// ----------------------------------------------------------------------------
// kbst_datapath
// Entry table, scan counter, match and free search, cursor delta, result reg.
// ----------------------------------------------------------------------------
`default_nettype none

module kbst_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire kbst_pkg::kbst_cmd_t          cmd,
  output      kbst_pkg::kbst_stat_t         stat,
  input  wire logic [1:0]                   in_command,
  input  wire logic [kbst_pkg::CODE_W-1:0]  in_code,
  input  wire logic                         in_is_button,
  input  wire logic [kbst_pkg::POS_W-1:0]   in_cursor_x,
  input  wire logic [kbst_pkg::POS_W-1:0]   in_cursor_y,
  output      logic                         out_valid,
  input  wire logic                         out_ready,
  output      logic [2:0]                   out_status,
  output      logic [kbst_pkg::DELTA_W-1:0] out_delta_x,
  output      logic [kbst_pkg::DELTA_W-1:0] out_delta_y,
  output      logic                         out_full
);

  import kbst_pkg::*;

  // captured item
  command_t            cmd_q;
  logic [CODE_W-1:0]   code_q;
  logic                btn_q;
  logic [POS_W-1:0]    cx_q;
  logic [POS_W-1:0]    cy_q;

  // scan control
  logic [CNT_W-1:0]       cnt;
  logic                   chk_valid;
  logic [IDX_W-1:0]       chk_idx;
  logic                   match_found;
  logic [IDX_W-1:0]       match_idx;
  status_t                match_status;
  logic                   free_found;
  logic [IDX_W-1:0]       free_idx;
  logic [TABLE_DEPTH-1:0] used;

  // cursor state
  logic [POS_W-1:0]   last_x;
  logic [POS_W-1:0]   last_y;
  logic [DELTA_W-1:0] held_dx;
  logic [DELTA_W-1:0] held_dy;
  logic [DELTA_W-1:0] dx_new;
  logic [DELTA_W-1:0] dy_new;

  // table RAM
  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;

  logic [CODE_W-1:0] ent_code;
  logic              ent_btn;
  status_t           ent_st;
  status_t           tick_st;
  logic              is_tick;
  logic              is_press;
  logic              is_release;
  logic              ent_used;
  logic              hit;
  logic              out_free;

  status_t           res_st;
  logic              res_full;

  kbst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  assign ent_code   = ram_rdata[CODE_W-1:0];
  assign ent_btn    = ram_rdata[CODE_W];
  assign ent_st     = status_t'(ram_rdata[CODE_W+3:CODE_W+1]);
  assign is_tick    = (cmd_q == CMD_TICK);
  assign is_press   = (cmd_q == CMD_PRESS);
  assign is_release = (cmd_q == CMD_RELEASE);
  assign ent_used   = chk_valid && used[chk_idx];
  assign hit        = ent_used && (ent_code == code_q) && (ent_btn == btn_q);
  assign tick_st    = (ent_st == ST_RELEASED) ? ST_ABSENT : advance_status(ent_st);

  assign dx_new = {cx_q[POS_W-1], cx_q} - {last_x[POS_W-1], last_x};
  assign dy_new = {cy_q[POS_W-1], cy_q} - {last_y[POS_W-1], last_y};

  assign out_free = !out_valid || out_ready;
  assign stat     = '{scan_last: (cnt == CNT_W'(TABLE_DEPTH)), out_free: out_free};

  // write port: tick write-back during the walk, press or release at finish
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = chk_idx;
    ram_wdata = {advance_status(ent_st), ent_btn, ent_code};
    if (cmd.step && is_tick && ent_used && (ent_st != ST_RELEASED)) begin
      ram_we = 1'b1;
    end else if (cmd.finish && is_press && !match_found && free_found) begin
      ram_we    = 1'b1;
      ram_waddr = free_idx;
      ram_wdata = {ST_REGISTERED, btn_q, code_q};
    end else if (cmd.finish && is_release && match_found && !btn_q) begin
      ram_we    = 1'b1;
      ram_waddr = match_idx;
      ram_wdata = {ST_UNREGISTERED, btn_q, code_q};
    end
  end

  always_comb begin
    res_st   = match_found ? match_status : ST_ABSENT;
    res_full = 1'b0;
    case (cmd_q)
      CMD_PRESS: begin
        if (!match_found) begin
          if (free_found) res_st = ST_REGISTERED;
          else            res_full = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (match_found && !btn_q) res_st = ST_UNREGISTERED;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt         <= '0;
      chk_valid   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      used        <= '0;
      last_x      <= '0;
      last_y      <= '0;
      held_dx     <= '0;
      held_dy     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.load) begin
        cnt         <= '0;
        chk_valid   <= 1'b0;
        match_found <= 1'b0;
        free_found  <= 1'b0;
      end
      if (cmd.step) begin
        // advance the read address, check the entry read last cycle
        chk_valid <= (cnt < CNT_W'(TABLE_DEPTH));
        if (cnt < CNT_W'(TABLE_DEPTH)) cnt <= cnt + 1'b1;
        if (hit) match_found <= 1'b1;
        if (chk_valid && !used[chk_idx] && !free_found) free_found <= 1'b1;
        if (is_tick && ent_used && (ent_st == ST_RELEASED)) used[chk_idx] <= 1'b0;
      end
      if (cmd.finish) begin
        if (is_press && !match_found && free_found) used[free_idx] <= 1'b1;
        if (is_tick) begin
          held_dx <= dx_new;
          held_dy <= dy_new;
          last_x  <= cx_q;
          last_y  <= cy_q;
        end
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q  <= command_t'(in_command);
      code_q <= in_code;
      btn_q  <= in_is_button;
      cx_q   <= in_cursor_x;
      cy_q   <= in_cursor_y;
    end
    if (cmd.step) begin
      chk_idx <= cnt[IDX_W-1:0];
      if (hit) begin
        match_idx    <= chk_idx;
        match_status <= is_tick ? tick_st : ent_st;
      end
      if (chk_valid && !used[chk_idx] && !free_found) free_idx <= chk_idx;
    end
    if (cmd.finish) begin
      out_status  <= res_st;
      out_full    <= res_full;
      out_delta_x <= is_tick ? dx_new : held_dx;
      out_delta_y <= is_tick ? dy_new : held_dy;
    end
  end

`ifndef SYNTH
  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> out_free)
    else $error("result finished while output register busy");

  a_full_absent: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_full) |-> (out_status == ST_ABSENT))
    else $error("dropped press reports a status");

  a_full_press: assert property (@(posedge clk) disable iff (rst)
    ($rose(out_valid) && out_full) |-> ($past(cmd_q) == CMD_PRESS))
    else $error("table full flagged on a non-press beat");

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH))
    else $error("scan counter beyond table depth");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_status <= ST_RELEASED))
    else $error("result status out of range");
`endif

endmodule

`default_nettype wire

@@ design/key_button_state_tracker_top.sv @@
// ----------------------------------------------------------------------------
// key_button_state_tracker_top
// Key and mouse button state table with per-frame cursor delta.
// ----------------------------------------------------------------------------
// Each input beat (press, release, frame tick or query) is taken when the
// block is idle and answers with one result beat: the status of the named
// code after the beat took effect, the cursor delta held from the last tick,
// and a flag for a press dropped on a full table. For each item the table
// RAM is walked one entry per cycle to find the code, the lowest free entry
// and, on a tick, to retire and advance entries. A finished result waits in
// an output register, so the next beat is taken while it is still pending.
`default_nettype none

module key_button_state_tracker_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output      logic        s_tready,
  // input_code[24:0], cursor_x[40:25], cursor_y[56:41], zero [63:57]
  input  wire logic [63:0] s_tdata,
  // command[1:0], is_button[2]
  input  wire logic [2:0]  s_tuser,
  output      logic        m_tvalid,
  input  wire logic        m_tready,
  // code_status[2:0], delta_x[19:3], delta_y[36:20], zero [39:37]
  output      logic [39:0] m_tdata,
  // table_full[0]
  output      logic [0:0]  m_tuser
);

  import kbst_pkg::*;

  kbst_cmd_t          cmd;
  kbst_stat_t         stat;
  logic [2:0]         out_status;
  logic [DELTA_W-1:0] out_delta_x;
  logic [DELTA_W-1:0] out_delta_y;
  logic               out_full;

  kbst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  kbst_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .in_command   (s_tuser[1:0]),
    .in_code      (s_tdata[CODE_W-1:0]),
    .in_is_button (s_tuser[2]),
    .in_cursor_x  (s_tdata[40:25]),
    .in_cursor_y  (s_tdata[56:41]),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_status   (out_status),
    .out_delta_x  (out_delta_x),
    .out_delta_y  (out_delta_y),
    .out_full     (out_full)
  );

  assign m_tdata = {3'b000, out_delta_y, out_delta_x, out_status};
  assign m_tuser = out_full;

endmodule

`default_nettype wire

@@ bench/tb_key_button_state_tracker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_button_state_tracker_top
// Self-checking bench for the key and button state tracker.
// ----------------------------------------------------------------------------
// A clocked driver sends press, release, tick and query beats from a queue.
// Each beat is predicted when it is taken, against a local copy of the table
// and cursor state. A clocked monitor checks every result beat, in order,
// against the oldest prediction. A directed opening walks the status cycle
// and the cursor extremes. Random traffic alternates press-heavy and
// release-heavy stretches, so the table both fills up and drains. Both sides
// throttle at random, and the receiver holds off once for a long stretch.

module tb_key_button_state_tracker_top;
  import kbst_pkg::*;

  typedef struct packed {
    command_t                   cmd;
    logic [CODE_W-1:0]          code;
    logic                       btn;
    logic signed [POS_W-1:0]    cx;
    logic signed [POS_W-1:0]    cy;
  } track_event_t;

  typedef struct packed {
    status_t                    status;
    logic signed [DELTA_W-1:0]  dx;
    logic signed [DELTA_W-1:0]  dy;
    logic                       full;
  } code_report_t;

  localparam int POOL_N      = 40;
  localparam int BTN_POOL_N  = 6;
  localparam int RANDOM_N    = 600;
  localparam int STRETCH     = 60;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 2 * (TABLE_DEPTH + 3);

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [2:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [0:0]  m_tuser;

  key_button_state_tracker_top uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Local copy of the tracker state
  logic                      trk_used   [TABLE_DEPTH] = '{default: 1'b0};
  logic [CODE_W-1:0]         trk_code   [TABLE_DEPTH];
  logic                      trk_btn    [TABLE_DEPTH];
  status_t                   trk_status [TABLE_DEPTH];
  logic signed [POS_W-1:0]   last_x = '0;
  logic signed [POS_W-1:0]   last_y = '0;
  logic signed [DELTA_W-1:0] held_dx = '0;
  logic signed [DELTA_W-1:0] held_dy = '0;

  track_event_t events_to_send [$];
  code_report_t reports_due [$];
  track_event_t offered;
  code_report_t want, got;
  logic [CODE_W-1:0] code_pool [POOL_N];
  int n_events = 0;
  int n_taken  = 0;
  int n_err    = 0;
  int send_gap_pct;
  int recv_gap_pct;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic int find_tracked(input logic [CODE_W-1:0] code, input logic btn);
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (trk_used[i] && trk_code[i] == code && trk_btn[i] == btn) return i;
    end
    return -1;
  endfunction

  // Apply one event to the local state and return the report it must produce
  function automatic code_report_t next_code_report(input track_event_t ev);
    code_report_t r;
    int hit;
    int slot;
    r.full = 1'b0;
    hit = find_tracked(ev.code, ev.btn);
    case (ev.cmd)
      CMD_PRESS: begin
        if (hit < 0) begin
          slot = -1;
          for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (!trk_used[i]) slot = i;
          end
          if (slot < 0) begin
            r.full = 1'b1;
          end else begin
            trk_used[slot]   = 1'b1;
            trk_code[slot]   = ev.code;
            trk_btn[slot]    = ev.btn;
            trk_status[slot] = ST_REGISTERED;
          end
        end
      end
      CMD_RELEASE: begin
        // buttons have no release
        if (hit >= 0 && !ev.btn) trk_status[hit] = ST_UNREGISTERED;
      end
      CMD_TICK: begin
        held_dx = {ev.cx[POS_W-1], ev.cx} - {last_x[POS_W-1], last_x};
        held_dy = {ev.cy[POS_W-1], ev.cy} - {last_y[POS_W-1], last_y};
        last_x  = ev.cx;
        last_y  = ev.cy;
        // drop released entries before advancing the rest
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (trk_used[i] && trk_status[i] == ST_RELEASED) trk_used[i] = 1'b0;
        end
        for (int i = 0; i < TABLE_DEPTH; i++) begin
          if (trk_used[i]) begin
            case (trk_status[i])
              ST_REGISTERED:   trk_status[i] = ST_TRIGGERED;
              ST_TRIGGERED:    trk_status[i] = ST_PRESSED;
              ST_UNREGISTERED: trk_status[i] = ST_RELEASED;
              default:         ;
            endcase
          end
        end
      end
      default: ;
    endcase
    hit = find_tracked(ev.code, ev.btn);
    r.status = (hit >= 0) ? trk_status[hit] : ST_ABSENT;
    r.dx = held_dx;
    r.dy = held_dy;
    return r;
  endfunction

  task automatic queue_event(input command_t cmd, input logic [CODE_W-1:0] code,
                             input logic btn, input logic [POS_W-1:0] cx,
                             input logic [POS_W-1:0] cy);
    track_event_t ev;
    ev.cmd  = cmd;
    ev.code = code;
    ev.btn  = btn;
    ev.cx   = cx;
    ev.cy   = cy;
    events_to_send = {events_to_send, ev};
  endtask

  always_comb begin
    if (n_taken < 200) begin
      send_gap_pct = 28;
      recv_gap_pct = 46;
    end else if (n_taken < 400) begin
      send_gap_pct = 46;
      recv_gap_pct = 28;
    end else begin
      send_gap_pct = 0;
      recv_gap_pct = 0;
    end
  end

  // Driver: predict each beat as it is taken, then offer the next one
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        reports_due = {reports_due, next_code_report(offered)};
        n_taken++;
      end
      if (!s_tvalid || s_tready) begin
        if (events_to_send.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          offered = events_to_send.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= {7'd0, offered.cy, offered.cx, offered.code};
          s_tuser  <= {offered.btn, offered.cmd};
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver readiness, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (!hold_done && n_taken >= 100) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (reports_due.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("unexpected result beat: tdata=%h tuser=%b", m_tdata, m_tuser);
      end else begin
        want = reports_due.pop_front();
        got.status = status_t'(m_tdata[2:0]);
        got.dx     = m_tdata[19:3];
        got.dy     = m_tdata[36:20];
        got.full   = m_tuser[0];
        if (got !== want) begin
          n_err++;
          if (n_err <= 10) begin
            $display("mismatch: status %0d/%0d dx %0d/%0d dy %0d/%0d full %0d/%0d (exp/act)",
                     want.status, got.status, want.dx, got.dx, want.dy, got.dy,
                     want.full, got.full);
          end
        end
      end
    end
  end

  initial begin
    track_event_t ev;
    bit press_heavy;
    int roll;
    for (int i = 0; i < POOL_N; i++) code_pool[i] = CODE_W'($urandom);
    // status cycle of one key, button that never releases, cursor extremes
    queue_event(CMD_QUERY,   '0, 1'b0, 16'sd0, 16'sd0);
    queue_event(CMD_PRESS,   '0, 1'b0, 16'sd0, 16'sd0);
    queue_event(CMD_PRESS,   '1, 1'b1, 16'sd0, 16'sd0);
    queue_event(CMD_PRESS,   '0, 1'b0, 16'sd0, 16'sd0);
    queue_event(CMD_TICK,    '0, 1'b0, 16'sh7FFF, 16'sh8000);
    queue_event(CMD_TICK,    '1, 1'b1, 16'sh8000, 16'sh7FFF);
    queue_event(CMD_TICK,    '0, 1'b0, 16'sh8000, 16'sh7FFF);
    queue_event(CMD_RELEASE, '0, 1'b0, 16'sh1234, 16'sh4321);
    queue_event(CMD_PRESS,   '0, 1'b0, 16'sh0000, 16'sh0000);
    queue_event(CMD_RELEASE, '1, 1'b1, 16'sh0000, 16'sh0000);
    queue_event(CMD_RELEASE, 25'h1555555, 1'b0, 16'sh0000, 16'sh0000);
    queue_event(CMD_QUERY,   '0, 1'b0, 16'sh5A5A, 16'shA5A5);
    queue_event(CMD_TICK,    '0, 1'b0, 16'sh0000, 16'sh0000);
    queue_event(CMD_TICK,    '0, 1'b0, 16'shFFFF, 16'sh0001);
    queue_event(CMD_PRESS,   '0, 1'b0, 16'sh7FFF, 16'sh7FFF);
    queue_event(CMD_QUERY,   '1, 1'b0, 16'sh0000, 16'sh0000);
    queue_event(CMD_RELEASE, '1, 1'b0, 16'sh0000, 16'sh0000);
    queue_event(CMD_QUERY,   '1, 1'b1, 16'sh0000, 16'sh0000);
    // alternate stretches so the table fills past capacity, then drains
    for (int k = 0; k < RANDOM_N; k++) begin
      press_heavy = ((k / STRETCH) % 2) == 0;
      roll = $urandom_range(99);
      if (press_heavy) begin
        ev.cmd = (roll < 65) ? CMD_PRESS : (roll < 72) ? CMD_RELEASE :
                 (roll < 87) ? CMD_TICK : CMD_QUERY;
      end else begin
        ev.cmd = (roll < 15) ? CMD_PRESS : (roll < 60) ? CMD_RELEASE :
                 (roll < 85) ? CMD_TICK : CMD_QUERY;
      end
      ev.btn = ($urandom_range(99) < 15);
      if ($urandom_range(9) == 0) begin
        ev.code = CODE_W'($urandom);
      end else if (ev.btn) begin
        ev.code = code_pool[$urandom_range(BTN_POOL_N - 1)];
      end else begin
        ev.code = code_pool[$urandom_range(POOL_N - 1)];
      end
      ev.cx = POS_W'($urandom);
      ev.cy = POS_W'($urandom);
      events_to_send = {events_to_send, ev};
    end
    n_events = events_to_send.size();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    wait (n_taken == n_events);
    wait (reports_due.size() == 0);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (n_err == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ key_button_state_tracker_top.f @@
design/kbst_pkg.sv
design/kbst_ram.sv
design/kbst_ctrl.sv
design/kbst_datapath.sv
design/key_button_state_tracker_top.sv
bench/tb_key_button_state_tracker_top.sv
